@@ src/life_generation_stencil_macros.svh @@
// Assertion macros shared by the life generation stencil RTL.
`ifndef LIFE_GENERATION_STENCIL_MACROS_SVH
`define LIFE_GENERATION_STENCIL_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define LGS_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("stencil check failed: same-cycle implication");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define LGS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("stencil check failed: next-cycle implication");

`endif

@@ src/lgs_pkg.sv @@
// Package: sizes, register codes and helper functions of the life stencil.
`default_nettype none
package lgs_pkg;

    localparam int MAX_WIDTH   = 256;
    localparam int MAX_HEIGHT  = 256;
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int ROW_W       = $clog2(MAX_HEIGHT);
    localparam int CFG_W       = 9;
    localparam int FIELD_W     = 8;
    localparam int WINDOW_ROWS = 3;
    localparam int ONES_W      = 2;
    localparam int COUNT_W     = 4;
    localparam int LINE_W      = 2;
    localparam int S_TDATA_W   = 8;
    localparam int M_TDATA_W   = 24;
    localparam int MIN_SIZE    = 3;

    localparam logic [COUNT_W-1:0] SURVIVE_COUNT = COUNT_W'(2);
    localparam logic [COUNT_W-1:0] BIRTH_COUNT   = COUNT_W'(3);

    typedef enum logic [0:0] {
        CFG_GRID_HEIGHT = 1'b0,
        CFG_GRID_WIDTH  = 1'b1
    } cfg_index_t;

    typedef logic [WINDOW_ROWS-1:0] column_t;

    // Live cells in one window column.
    function automatic logic [ONES_W-1:0] ones3(column_t col);
        return ONES_W'(col[0]) + ONES_W'(col[1]) + ONES_W'(col[2]);
    endfunction

    // Last valid column index for a size register, size saturated to [3, max].
    function automatic logic [COL_W-1:0] last_col(logic [CFG_W-1:0] size);
        logic [CFG_W:0] ext;
        ext = {1'b0, size};
        if (ext < (CFG_W+1)'(MIN_SIZE))
            return COL_W'(MIN_SIZE - 1);
        else if (int'(ext) > MAX_WIDTH)
            return COL_W'(MAX_WIDTH - 1);
        else
            return COL_W'(ext - 1'b1);
    endfunction

    // Last valid row index for a size register, size saturated to [3, max].
    function automatic logic [ROW_W-1:0] last_row(logic [CFG_W-1:0] size);
        logic [CFG_W:0] ext;
        ext = {1'b0, size};
        if (ext < (CFG_W+1)'(MIN_SIZE))
            return ROW_W'(MIN_SIZE - 1);
        else if (int'(ext) > MAX_HEIGHT)
            return ROW_W'(MAX_HEIGHT - 1);
        else
            return ROW_W'(ext - 1'b1);
    endfunction

endpackage
`default_nettype wire

@@ src/lgs_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module lgs_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule
`default_nettype wire

@@ src/lgs_cell.sv @@
// Window cell: holds one three-cell column and passes it on at each shift.
`default_nettype none
module lgs_cell (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          shift,
    input  wire lgs_pkg::column_t              col_in,
    output lgs_pkg::column_t                   col_q
);

    lgs_pkg::column_t col_reg;
    lgs_pkg::column_t col_next;

    always_comb
    begin
        col_next = shift ? col_in : col_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
        end
    end

    assign col_q = col_reg;

endmodule
`default_nettype wire

@@ src/life_generation_stencil.sv @@
// Top level: one B3/S23 generation over a raster stream of cell bits.
//
// Usage
//   Cells arrive on the s_axis channel in raster order, one bit per transfer
//   (s_axis_tdata[0], 1 = alive), grid_height rows of grid_width columns,
//   sizes saturated to [3, 256]. Border cells are treated as dead.
//   For every interior cell (r-1, c-1) one result leaves on m_axis once cell
//   (r, c) has been taken: next value, row and column; tlast marks the final
//   interior cell of the generation. Generations follow back to back.
//   Throughput: one cell per cycle while the receiver does not stall. The cell
//   that completes a window passes stage 1, alongside the registered read of
//   the line store, and then the output register before its result is valid.
//   The receiver may stall at any time: the output register holds, the
//   middle stage waits, and s_axis_tready falls only when both are full.
//   Configuration: cfg_we with cfg_index 0 (height) or 1 (width) writes a
//   size and restarts the raster at row 0, column 0. Write only while idle.
//   Reset: sizes return to 256, raster position and window clear; the line
//   store needs no clearing since rows 0 and 1 refill it before any result.
`default_nettype none
`include "life_generation_stencil_macros.svh"
module life_generation_stencil (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // Configuration write port
    input  wire logic                            cfg_we,
    input  wire logic [0:0]                      cfg_index,
    input  wire logic [lgs_pkg::CFG_W-1:0]       cfg_data,
    // Cell stream in
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire logic [lgs_pkg::S_TDATA_W-1:0]   s_axis_tdata,  // [0] cell_alive
    // Result stream out
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    output logic [lgs_pkg::M_TDATA_W-1:0]        m_axis_tdata,  // [0] next_alive,
                                                                 // [8:1] cell_row,
                                                                 // [16:9] cell_col
    output logic                                 m_axis_tlast   // last_of_generation
);

    // Configuration registers
    logic [lgs_pkg::CFG_W-1:0] grid_height_reg;
    logic [lgs_pkg::CFG_W-1:0] grid_width_reg;
    logic [lgs_pkg::ROW_W-1:0] h_last;
    logic [lgs_pkg::COL_W-1:0] w_last;

    // Raster position of the next cell
    logic [lgs_pkg::ROW_W-1:0] row_pos_reg;
    logic [lgs_pkg::ROW_W-1:0] row_pos_next;
    logic [lgs_pkg::COL_W-1:0] col_pos_reg;
    logic [lgs_pkg::COL_W-1:0] col_pos_next;

    // Line store read stage
    logic                      s1_valid_reg;
    logic                      s1_cur_reg;
    logic [lgs_pkg::ROW_W-1:0] s1_row_reg;
    logic [lgs_pkg::COL_W-1:0] s1_col_reg;
    logic                      s1_emit_reg;
    logic                      s1_last_reg;

    // Output register
    logic                        out_valid_reg;
    logic                        out_alive_reg;
    logic [lgs_pkg::FIELD_W-1:0] out_row_reg;
    logic [lgs_pkg::FIELD_W-1:0] out_col_reg;
    logic                        out_last_reg;

    logic                        in_xfer;
    logic                        s1_advance;
    logic                        border;
    logic                        cur_masked;
    logic [lgs_pkg::LINE_W-1:0]  line_rdata;
    lgs_pkg::column_t            new_col;
    lgs_pkg::column_t            cell0_col;
    lgs_pkg::column_t            cell1_col;
    logic [lgs_pkg::COUNT_W-1:0] total;
    logic [lgs_pkg::COUNT_W-1:0] neighbours;
    logic                        centre;
    logic                        next_alive;

    assign h_last = lgs_pkg::last_row(grid_height_reg);
    assign w_last = lgs_pkg::last_col(grid_width_reg);

    // Handshakes: the middle stage moves on whenever the output register is
    // free or being emptied; input is taken whenever the middle stage frees.
    assign s1_advance    = s1_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !s1_valid_reg || s1_advance;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    // Force the border dead
    assign border     = (row_pos_reg == '0) || (row_pos_reg == h_last) ||
                        (col_pos_reg == '0) || (col_pos_reg == w_last);
    assign cur_masked = s_axis_tdata[0] && !border;

    // Advance the raster position, wrapping at row and grid end; cfg_we clears it
    always_comb
    begin
        row_pos_next = row_pos_reg;
        col_pos_next = col_pos_reg;
        if (cfg_we)
        begin
            row_pos_next = '0;
            col_pos_next = '0;
        end
        else if (in_xfer)
        begin
            if (col_pos_reg == w_last)
            begin
                col_pos_next = '0;
                row_pos_next = (row_pos_reg == h_last) ? '0 : row_pos_reg + 1'b1;
            end
            else
            begin
                col_pos_next = col_pos_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_height_reg <= lgs_pkg::CFG_W'(lgs_pkg::MAX_HEIGHT);
            grid_width_reg  <= lgs_pkg::CFG_W'(lgs_pkg::MAX_WIDTH);
            row_pos_reg     <= '0;
            col_pos_reg     <= '0;
        end
        else
        begin
            row_pos_reg <= row_pos_next;
            col_pos_reg <= col_pos_next;
            if (cfg_we)
            begin
                case (lgs_pkg::cfg_index_t'(cfg_index))
                    lgs_pkg::CFG_GRID_HEIGHT: grid_height_reg <= cfg_data;
                    lgs_pkg::CFG_GRID_WIDTH:  grid_width_reg  <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // Line store: bit 1 holds the row above, bit 0 the row two above. Read on
    // the input transfer, rewrite the same column as the cell leaves stage 1.
    // The next access to that column lies at least three cells later.
    lgs_ram #(
        .WIDTH (lgs_pkg::LINE_W),
        .DEPTH (lgs_pkg::MAX_WIDTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (s1_advance),
        .waddr (s1_col_reg),
        .wdata ({s1_cur_reg, line_rdata[1]}),
        .re    (in_xfer),
        .raddr (col_pos_reg),
        .rdata (line_rdata)
    );

    // Stage 1: hold the cell and its tags while the line store is read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_xfer)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_cur_reg  <= cur_masked;
            s1_row_reg  <= row_pos_reg;
            s1_col_reg  <= col_pos_reg;
            s1_emit_reg <= (row_pos_reg >= lgs_pkg::ROW_W'(2)) &&
                           (col_pos_reg >= lgs_pkg::COL_W'(2));
            s1_last_reg <= (row_pos_reg == h_last) && (col_pos_reg == w_last);
        end
    end

    // Window: the newest column is the stage 1 cell under the line store bits,
    // the two older ones sit in a chain of cells that shifts once per cell.
    assign new_col = {s1_cur_reg, line_rdata[1], line_rdata[0]};

    lgs_cell u_cell0 (
        .clk    (clk),
        .rst_n  (rst_n),
        .shift  (s1_advance),
        .col_in (new_col),
        .col_q  (cell0_col)
    );

    lgs_cell u_cell1 (
        .clk    (clk),
        .rst_n  (rst_n),
        .shift  (s1_advance),
        .col_in (cell0_col),
        .col_q  (cell1_col)
    );

    // B3/S23 rule on the window centred on the middle cell of cell 0
    assign centre     = cell0_col[1];
    assign total      = lgs_pkg::COUNT_W'(lgs_pkg::ones3(new_col)) +
                        lgs_pkg::COUNT_W'(lgs_pkg::ones3(cell0_col)) +
                        lgs_pkg::COUNT_W'(lgs_pkg::ones3(cell1_col));
    assign neighbours = total - lgs_pkg::COUNT_W'(centre);
    assign next_alive = (neighbours == lgs_pkg::BIRTH_COUNT) ||
                        (centre && (neighbours == lgs_pkg::SURVIVE_COUNT));

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_advance)
        begin
            out_valid_reg <= s1_emit_reg;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance && s1_emit_reg)
        begin
            out_alive_reg <= next_alive;
            out_row_reg   <= lgs_pkg::FIELD_W'(s1_row_reg - 1'b1);
            out_col_reg   <= lgs_pkg::FIELD_W'(s1_col_reg - 1'b1);
            out_last_reg  <= s1_last_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {
        (lgs_pkg::M_TDATA_W - 2 * lgs_pkg::FIELD_W - 1)'(0),
        out_col_reg,
        out_row_reg,
        out_alive_reg
    };

    // Input is never taken while stage 1 is full and stuck
    `LGS_ASSERT_IMPLIES(a_no_overrun, in_xfer, !s1_valid_reg || s1_advance)
    // An interior result always enters the output register
    `LGS_ASSERT_NEXT(a_result_lands, s1_advance && s1_emit_reg, out_valid_reg)
    // Reported cells are never on the top row or left column
    `LGS_ASSERT_IMPLIES(a_interior_only, out_valid_reg,
                        (out_row_reg != '0) && (out_col_reg != '0))
    // The raster column never passes the last column in use
    `LGS_ASSERT_IMPLIES(a_col_in_range, 1'b1, col_pos_reg <= w_last)

endmodule
`default_nettype wire

@@ bench/life_stencil_check_pkg.sv @@
`timescale 1ns / 1ps
// Scoreboard class that predicts and checks next-generation cells of the life stencil.
package life_stencil_check_pkg;
    import lgs_pkg::*;

    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic                next_alive;
        logic [FIELD_W-1:0]  cell_row;
        logic [FIELD_W-1:0]  cell_col;
        logic                last_of_generation;
    } cell_result_t;

    class generation_tracker;
        logic [CFG_W-1:0] height_reg;
        logic [CFG_W-1:0] width_reg;
        bit               upper_line [MAX_WIDTH];
        bit               middle_line [MAX_WIDTH];
        bit [8:0]         window;
        int unsigned      row_pos;
        int unsigned      col_pos;
        cell_result_t     next_gen_q [$];
        int unsigned      mismatches;
        int unsigned      strays;
        int unsigned      reported;

        function new();
            height_reg = CFG_W'(MAX_HEIGHT);
            width_reg  = CFG_W'(MAX_WIDTH);
            foreach (upper_line[i])
            begin
                upper_line[i]  = 1'b0;
                middle_line[i] = 1'b0;
            end
            window     = '0;
            row_pos    = 0;
            col_pos    = 0;
            mismatches = 0;
            strays     = 0;
            reported   = 0;
        endfunction

        static function int unsigned saturate(int unsigned v, int unsigned top);
            if (v < MIN_SIZE)
                return MIN_SIZE;
            if (v > top)
                return top;
            return v;
        endfunction

        function int unsigned rows_used();
            return saturate(height_reg, MAX_HEIGHT);
        endfunction

        function int unsigned cols_used();
            return saturate(width_reg, MAX_WIDTH);
        endfunction

        // A size write restarts the raster at the top-left corner.
        function void write_size(cfg_index_t idx, logic [CFG_W-1:0] value);
            if (idx == CFG_GRID_HEIGHT)
                height_reg = value;
            else
                width_reg = value;
            row_pos = 0;
            col_pos = 0;
        endfunction

        function void note_cell(logic [S_TDATA_W-1:0] bits);
            int unsigned  h;
            int unsigned  w;
            int unsigned  r;
            int unsigned  c;
            int unsigned  live;
            bit           cur;
            bit           up;
            bit           mid;
            bit           centre;
            cell_result_t want;
            h = rows_used();
            w = cols_used();
            r = (row_pos >= h) ? 0 : row_pos;
            c = (col_pos >= w) ? 0 : col_pos;
            cur = bits[0];
            if (r == 0 || r == h - 1 || c == 0 || c == w - 1)
                cur = 1'b0;
            up  = upper_line[c];
            mid = middle_line[c];
            upper_line[c]  = mid;
            middle_line[c] = cur;
            // newest column in the low bits: top, middle, bottom
            window = {window[5:0], cur, mid, up};
            if (r >= 2 && c >= 2)
            begin
                centre = window[4];
                live = 0;
                for (int i = 0; i < 9; i++)
                    live += window[i];
                live -= centre;
                if (centre)
                    want.next_alive = (live == SURVIVE_COUNT || live == BIRTH_COUNT);
                else
                    want.next_alive = (live == BIRTH_COUNT);
                want.cell_row = FIELD_W'(r - 1);
                want.cell_col = FIELD_W'(c - 1);
                want.last_of_generation = (r == h - 1 && c == w - 1);
                next_gen_q.push_back(want);
            end
            c++;
            if (c >= w)
            begin
                c = 0;
                r++;
                if (r >= h)
                    r = 0;
            end
            row_pos = r;
            col_pos = c;
        endfunction

        function void check_result(logic [M_TDATA_W-1:0] data, logic last);
            cell_result_t got;
            cell_result_t want;
            got.next_alive         = data[0];
            got.cell_row           = data[8:1];
            got.cell_col           = data[16:9];
            got.last_of_generation = last;
            if (next_gen_q.size() == 0)
            begin
                strays++;
                if (reported < MAX_REPORTS)
                    $display("%0t: unexpected cell result alive=%0b row=%0d col=%0d last=%0b",
                             $realtime, got.next_alive, got.cell_row, got.cell_col,
                             got.last_of_generation);
                reported++;
                return;
            end
            want = next_gen_q.pop_front();
            if (got.next_alive != want.next_alive || got.cell_row != want.cell_row ||
                got.cell_col != want.cell_col ||
                got.last_of_generation != want.last_of_generation)
            begin
                mismatches++;
                if (reported < MAX_REPORTS)
                begin
                    $write("%0t: cell mismatch expected alive=%0b row=%0d col=%0d last=%0b",
                           $realtime, want.next_alive, want.cell_row, want.cell_col,
                           want.last_of_generation);
                    $display(" got alive=%0b row=%0d col=%0d last=%0b", got.next_alive,
                             got.cell_row, got.cell_col, got.last_of_generation);
                end
                reported++;
            end
        endfunction

        function int unsigned outstanding();
            return next_gen_q.size();
        endfunction

        function int unsigned failures();
            return mismatches + strays + outstanding();
        endfunction
    endclass
endpackage

@@ bench/life_generation_stencil_tb.sv @@
`timescale 1ns / 1ps
// Self-checking bench for life_generation_stencil: random raster streams against a predictor.
module life_generation_stencil_tb;
    import lgs_pkg::*;
    import life_stencil_check_pkg::*;

    localparam int unsigned RANDOM_ITEMS   = 300;
    localparam int unsigned SETTLE_CYCLES  = 8;     // lets the pipeline empty after the last result
    localparam int unsigned LONG_HOLD      = 300;   // receiver hold-off for back-pressure
    localparam int unsigned WATCHDOG_LIMIT = 4000;
    localparam int unsigned STRIP_WIDTH    = 20;    // grid width for the back-pressure run

    // Interior pattern on a 5x5 grid with a live border that must read as dead.
    // Covers survival on two and on three, overcrowding and a birth.
    localparam logic [24:0] DIRECTED_5X5 = {5'b11111, 5'b10001, 5'b10111, 5'b11111, 5'b11111};

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [0:0]            cfg_index = CFG_GRID_HEIGHT;
    logic [CFG_W-1:0]      cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata = '0;    // [0] cell_alive
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_axis_tdata;         // [0] next_alive, [8:1] cell_row, [16:9] cell_col
    logic                  m_axis_tlast;         // last_of_generation

    generation_tracker board;

    bit          src_calm = 1'b0;
    bit          sink_calm = 1'b0;
    int unsigned sink_stall = 0;
    int unsigned hold_left = 0;
    int unsigned hold_requests = 0;   // raised by the stimulus
    int unsigned holds_served = 0;    // followed by the receiver
    int unsigned idle_cycles = 0;

    life_generation_stencil DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Gap lengths: mostly none or short, now and then a long one.
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Size register values: mostly small grids, some below the minimum.
    function automatic logic [CFG_W-1:0] pick_size();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 75)
            return CFG_W'($urandom_range(3, 12));
        if (roll < 88)
            return CFG_W'($urandom_range(0, 2));
        return CFG_W'($urandom_range(13, 24));
    endfunction

    // Offer one cell, hold it until the transfer, then note it for prediction.
    task automatic send_cell(logic [S_TDATA_W-1:0] bits);
        int unsigned gap;
        if ($urandom_range(0, 63) == 0)
            src_calm = !src_calm;
        gap = src_calm ? 0 : pick_gap();
        if (gap != 0)
        begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = bits;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        board.note_cell(bits);
        @(negedge clk);
    endtask

    // Stream random cells; bits above the cell bit are random noise the block must ignore.
    task automatic pump_cells(int unsigned count, int unsigned alive_pct);
        logic [S_TDATA_W-1:0] bits;
        for (int unsigned n = 0; n < count; n++)
        begin
            bits    = S_TDATA_W'($urandom);
            bits[0] = ($urandom_range(0, 99) < alive_pct);
            send_cell(bits);
        end
    endtask

    // Drop valid, wait for every predicted cell, then let the pipeline empty.
    task automatic drain();
        s_axis_tvalid = 1'b0;
        while (board.outstanding() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [CFG_W-1:0] value);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        board.write_size(idx, value);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // Receiver: random stalls, calm stretches, and the long hold-off on request.
    always @(negedge clk)
    begin
        if (!rst_n)
            m_axis_tready = 1'b0;
        else
        begin
            if (holds_served != hold_requests)
            begin
                holds_served = hold_requests;
                hold_left    = LONG_HOLD;
            end
            if (hold_left != 0)
            begin
                m_axis_tready = 1'b0;
                hold_left--;
            end
            else if (sink_stall != 0)
            begin
                m_axis_tready = 1'b0;
                sink_stall--;
            end
            else
            begin
                if ($urandom_range(0, 199) == 0)
                    sink_calm = !sink_calm;
                sink_stall = sink_calm ? 0 : pick_gap();
                if (sink_stall != 0)
                begin
                    m_axis_tready = 1'b0;
                    sink_stall--;
                end
                else
                    m_axis_tready = 1'b1;
            end
        end
    end

    // Check every result transfer against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            board.check_result(m_axis_tdata, m_axis_tlast);
    end

    // Watchdog: count cycles with no transfer on either side.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles = 0;
        else if (rst_n)
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        int unsigned random_items;
        int unsigned choice;
        int unsigned area;
        int unsigned cells;
        bit          first_phase;
        logic [S_TDATA_W-1:0] bits;

        board = new();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Sizes below the minimum saturate to 3x3; a lone live centre dies.
        write_reg(CFG_GRID_HEIGHT, CFG_W'(0));
        write_reg(CFG_GRID_WIDTH, CFG_W'(2));
        for (int i = 0; i < 9; i++)
            send_cell('1);
        drain();

        // Fixed pattern on 5x5 with every border cell offered as live.
        write_reg(CFG_GRID_HEIGHT, CFG_W'(5));
        write_reg(CFG_GRID_WIDTH, CFG_W'(5));
        for (int i = 0; i < 25; i++)
        begin
            bits    = S_TDATA_W'($urandom);
            bits[0] = DIRECTED_5X5[i];
            send_cell(bits);
        end
        drain();

        // Narrow strip, flattest height; hold the receiver off meanwhile so the
        // block fills and pushes back on the sender.
        write_reg(CFG_GRID_HEIGHT, CFG_W'(1));
        write_reg(CFG_GRID_WIDTH, CFG_W'(STRIP_WIDTH));
        src_calm = 1'b1;
        hold_requests++;
        pump_cells(board.rows_used() * board.cols_used(), 40);
        drain();

        // Random phases: new sizes, whole generations back to back, some cut
        // short so the next write restarts mid-grid.
        random_items = 0;
        first_phase  = 1'b1;
        while (random_items < RANDOM_ITEMS)
        begin
            choice = first_phase ? 2 : $urandom_range(0, 2);
            first_phase = 1'b0;
            if (choice != 1)
                write_reg(CFG_GRID_HEIGHT, pick_size());
            if (choice != 0)
                write_reg(CFG_GRID_WIDTH, pick_size());
            area  = board.rows_used() * board.cols_used();
            cells = (area > 100) ? area : area * $urandom_range(1, 3);
            if ($urandom_range(0, 3) == 0)
                cells = $urandom_range(1, cells);
            pump_cells(cells, $urandom_range(10, 70));
            random_items += cells;
            drain();
        end

        if (board.failures() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule

@@ files.f @@
+incdir+src
src/lgs_pkg.sv
src/lgs_ram.sv
src/lgs_cell.sv
src/life_generation_stencil.sv
bench/life_stencil_check_pkg.sv
bench/life_generation_stencil_tb.sv
